// File: hdl/sedsh_pkg.sv
// sedsh_pkg: shared widths, constants and stage types of the soft edge disc shader
// no dependencies; every module of the block imports it

package sedsh_pkg;

    // field widths
    localparam int OFFSET_BITS = 9;
    localparam int FRAC_BITS   = 4;
    localparam int RADIUS_W    = 12;
    localparam int COLOR_W     = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 2'd3;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 12'd80;

    // distance datapath
    localparam int MAG_W  = OFFSET_BITS;
    localparam int SUM_W  = 2 * OFFSET_BITS;
    localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W = OFFSET_BITS + FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;

    // fade datapath
    localparam int CMP_W   = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;
    localparam int DIFF_W  = ROOT_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SQ25_W  = SQ_W + 5;
    localparam logic [SQ25_W-1:0] FADE_DENOM = SQ25_W'(36 << (2 * FRAC_BITS));
    localparam int S_FRAC  = 12;
    localparam int S_W     = S_FRAC + 1;
    localparam logic [S_W-1:0] S_ONE = S_W'(1 << S_FRAC);
    // quotient by nine of a value below 9 * 4096, by reciprocal
    localparam int M_W         = 16;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
    localparam int PROD9_W = M_W + RECIP_W;
    localparam int BLEND_W = COLOR_W + S_W;

    // front 3, one per root bit, fade 5, blend 2
    localparam int LATENCY = 3 + ROOT_W + 5 + 2;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] dist_q;
    } t_dist;

    typedef struct packed {
        logic           valid;
        logic           in_disc;
        logic [S_W-1:0] fade;
    } t_fade;

endpackage

// File: hdl/sedsh_root_step.sv
// sedsh_root_step: one registered digit step of the square root pipeline
// depends on sedsh_pkg (t_root)

module sedsh_root_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sedsh_pkg::t_root i_stage,
    output sedsh_pkg::t_root o_stage
);
    import sedsh_pkg::*;

    t_root              r_stage;
    logic [REM_W+1:0]   cat;
    logic [REM_W+1:0]   trial;
    logic               take;
    logic [REM_W-1:0]   n_rem;
    logic [ROOT_W-1:0]  n_root;

    // bring down the next two radicand bits and try root*4+1
    assign cat   = {i_stage.rem, i_stage.rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, i_stage.root, 2'b01};
    assign take  = (cat >= trial);

    always_comb begin
        if (take) begin
            n_rem  = REM_W'(cat - trial);
            n_root = {i_stage.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = REM_W'(cat);
            n_root = {i_stage.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
        r_stage.rad  <= {i_stage.rad[RAD_W-3:0], 2'b00};
        r_stage.rem  <= n_rem;
        r_stage.root <= n_root;
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/sedsh_dist.sv
// sedsh_dist: magnitude, squares and pipelined integer square root of the pixel offset
// depends on sedsh_pkg and sedsh_root_step

module sedsh_dist (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [sedsh_pkg::OFFSET_BITS-1:0] i_offset_x,
    input  logic signed [sedsh_pkg::OFFSET_BITS-1:0] i_offset_y,
    output sedsh_pkg::t_dist                      o_dist
);
    import sedsh_pkg::*;

    logic               r_a_valid;
    logic [MAG_W-1:0]   r_ax;
    logic [MAG_W-1:0]   r_ay;
    logic               r_b_valid;
    logic [SUM_W-1:0]   r_sqx;
    logic [SUM_W-1:0]   r_sqy;
    t_root              r_head;
    logic [MAG_W-1:0]   n_ax;
    logic [MAG_W-1:0]   n_ay;
    logic [SUM_W-1:0]   n_sum;
    t_root              chain [ROOT_W+1];

    // magnitude as unsigned, the most negative offset keeps its top bit
    assign n_ax  = i_offset_x[OFFSET_BITS-1] ? MAG_W'(-i_offset_x) : MAG_W'(i_offset_x);
    assign n_ay  = i_offset_y[OFFSET_BITS-1] ? MAG_W'(-i_offset_y) : MAG_W'(i_offset_y);
    assign n_sum = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_head.valid <= 1'b0;
        end else begin
            r_a_valid    <= i_valid;
            r_b_valid    <= r_a_valid;
            r_head.valid <= r_b_valid;
        end
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_sqx       <= SUM_W'(r_ax * r_ax);
        r_sqy       <= SUM_W'(r_ay * r_ay);
        r_head.rad  <= {n_sum, {(2 * FRAC_BITS){1'b0}}};
        r_head.rem  <= '0;
        r_head.root <= '0;
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        sedsh_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    assign o_dist.valid  = chain[ROOT_W].valid;
    assign o_dist.dist_q = chain[ROOT_W].root;

endmodule

// File: hdl/sedsh_fade.sv
// sedsh_fade: distance against radius, squared edge distance and the Q1.12 fade factor
// depends on sedsh_pkg (t_dist, t_fade, fade constants)

module sedsh_fade (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [sedsh_pkg::RADIUS_W-1:0] i_radius,
    input  sedsh_pkg::t_dist               i_dist,
    output sedsh_pkg::t_fade               o_fade
);
    import sedsh_pkg::*;

    logic [CMP_W-1:0]        d_ext;
    logic [CMP_W-1:0]        r_ext;
    logic [CMP_W-1:0]        n_diff_full;
    logic                    r1_valid;
    logic                    r1_inside;
    logic [DIFF_W-1:0]       r1_diff;
    logic                    r2_valid;
    logic                    r2_inside;
    logic [SQ_W-1:0]         r2_sq;
    logic                    r3_valid;
    logic                    r3_inside;
    logic [SQ25_W-1:0]       r3_sq25;
    logic [SQ25_W+S_FRAC-1:0] m_wide;
    logic [M_W-1:0]          n_m;
    logic                    r4_valid;
    logic                    r4_inside;
    logic                    r4_sat;
    logic [PROD9_W-1:0]      r4_prod;
    t_fade                   r5_fade;

    assign d_ext       = CMP_W'(i_dist.dist_q);
    assign r_ext       = CMP_W'(i_radius);
    assign n_diff_full = d_ext - r_ext;

    // (sq*25*4096) / (36 << 2F) is (sq*25*4096 >> (2F+2)) / 9, below 9*4096 when unsaturated
    assign m_wide = {r3_sq25, {S_FRAC{1'b0}}} >> (2 * FRAC_BITS + 2);
    assign n_m    = m_wide[M_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r4_valid      <= 1'b0;
            r5_fade.valid <= 1'b0;
        end else begin
            r1_valid      <= i_dist.valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r5_fade.valid <= r4_valid;
        end
        r1_inside       <= (d_ext < r_ext);
        r1_diff         <= n_diff_full[DIFF_W-1:0];
        r2_inside       <= r1_inside;
        r2_sq           <= r1_diff * r1_diff;
        r3_inside       <= r2_inside;
        r3_sq25         <= (SQ25_W'(r2_sq) << 4) + (SQ25_W'(r2_sq) << 3) + SQ25_W'(r2_sq);
        r4_inside       <= r3_inside;
        r4_sat          <= (r3_sq25 >= FADE_DENOM);
        r4_prod         <= PROD9_W'(n_m * RECIP_NINE);
        r5_fade.in_disc <= r4_inside;
        if (r4_sat) begin
            r5_fade.fade <= S_ONE;
        end else begin
            r5_fade.fade <= {1'b0, r4_prod[RECIP_SHIFT +: S_FRAC]};
        end
    end

    assign o_fade = r5_fade;

endmodule

// File: hdl/sedsh_blend.sv
// sedsh_blend: outside the disc, fades each colour channel toward white by the fade factor
// depends on sedsh_pkg (t_fade, colour and blend widths)

module sedsh_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sedsh_pkg::COLOR_W-1:0] i_fill_red,
    input  logic [sedsh_pkg::COLOR_W-1:0] i_fill_green,
    input  logic [sedsh_pkg::COLOR_W-1:0] i_fill_blue,
    input  sedsh_pkg::t_fade              i_fade,
    output logic                          o_valid,
    output logic [sedsh_pkg::COLOR_W-1:0] o_shade_red,
    output logic [sedsh_pkg::COLOR_W-1:0] o_shade_green,
    output logic [sedsh_pkg::COLOR_W-1:0] o_shade_blue,
    output logic                          o_inside_disc
);
    import sedsh_pkg::*;

    localparam logic [COLOR_W-1:0] WHITE = '1;

    logic               r1_valid;
    logic               r1_inside;
    logic [BLEND_W-1:0] r1_prod_r;
    logic [BLEND_W-1:0] r1_prod_g;
    logic [BLEND_W-1:0] r1_prod_b;
    logic               r2_valid;
    logic               r2_inside;
    logic [COLOR_W-1:0] r2_red;
    logic [COLOR_W-1:0] r2_green;
    logic [COLOR_W-1:0] r2_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_fade.valid;
            r2_valid <= r1_valid;
        end
        r1_inside <= i_fade.in_disc;
        r1_prod_r <= BLEND_W'((WHITE - i_fill_red) * i_fade.fade);
        r1_prod_g <= BLEND_W'((WHITE - i_fill_green) * i_fade.fade);
        r1_prod_b <= BLEND_W'((WHITE - i_fill_blue) * i_fade.fade);
        r2_inside <= r1_inside;
        // inside the disc the plain fill colour goes out
        if (r1_inside) begin
            r2_red   <= i_fill_red;
            r2_green <= i_fill_green;
            r2_blue  <= i_fill_blue;
        end else begin
            r2_red   <= i_fill_red + r1_prod_r[S_FRAC +: COLOR_W];
            r2_green <= i_fill_green + r1_prod_g[S_FRAC +: COLOR_W];
            r2_blue  <= i_fill_blue + r1_prod_b[S_FRAC +: COLOR_W];
        end
    end

    assign o_valid       = r2_valid;
    assign o_inside_disc = r2_inside;
    assign o_shade_red   = r2_red;
    assign o_shade_green = r2_green;
    assign o_shade_blue  = r2_blue;

endmodule

// File: hdl/soft_edge_disc_shader.sv
// soft_edge_disc_shader: top level, configuration registers and the shading pipeline
// depends on sedsh_pkg, sedsh_dist, sedsh_fade and sedsh_blend
//
// Shades one pixel of a filled disc whose edge fades to white.
// Input: a pixel offset from the disc centre (i_offset_x, i_offset_y, signed) is
// taken at each rising edge where start is high and busy is low. busy is high only
// while reset is held, so one pixel can be taken every clock.
// Output: each result shows on o_shade_red/green/blue and o_inside_disc for exactly
// one cycle, marked by o_valid. Results leave in the order the pixels came in.
// Pipeline: from the accepting edge to the cycle in which o_valid is high, a pixel passes
// 3 front stages (magnitude, squares, sum), one stage per root bit of the 13-bit
// distance, 5 fade stages and 2 blend stages. Throughput is one pixel per cycle.
// Configuration: i_cfg_we writes i_cfg_wdata to the register at i_cfg_idx
// (0 radius in pixels with four fraction bits, 1 red, 2 green, 3 blue). The
// registers are read down the pipeline, so write them only while no pixel is in flight.
// Reset: synchronous and active low; it drops every pixel in flight and sets the
// radius to 5.0 pixels and the fill colour to black.
// The receiver cannot stall; the pipeline never holds.

module soft_edge_disc_shader (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [sedsh_pkg::OFFSET_BITS-1:0] i_offset_x,
    input  logic signed [sedsh_pkg::OFFSET_BITS-1:0] i_offset_y,
    input  logic                                     i_cfg_we,
    input  logic [sedsh_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [sedsh_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    output logic                                     o_valid,
    output logic [sedsh_pkg::COLOR_W-1:0]            o_shade_red,
    output logic [sedsh_pkg::COLOR_W-1:0]            o_shade_green,
    output logic [sedsh_pkg::COLOR_W-1:0]            o_shade_blue,
    output logic                                     o_inside_disc
);
    import sedsh_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    logic [COLOR_W-1:0]  r_fill_red;
    logic [COLOR_W-1:0]  r_fill_green;
    logic [COLOR_W-1:0]  r_fill_blue;
    logic                accept;
    t_dist               pix_dist;
    t_fade               fade;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RESET;
            r_fill_red   <= '0;
            r_fill_green <= '0;
            r_fill_blue  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius     <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_RED:    r_fill_red   <= i_cfg_wdata[COLOR_W-1:0];
                CFG_GREEN:  r_fill_green <= i_cfg_wdata[COLOR_W-1:0];
                CFG_BLUE:   r_fill_blue  <= i_cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    sedsh_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_offset_x (i_offset_x),
        .i_offset_y (i_offset_y),
        .o_dist     (pix_dist)
    );

    sedsh_fade u_fade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radius (r_radius),
        .i_dist   (pix_dist),
        .o_fade   (fade)
    );

    sedsh_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fill_red    (r_fill_red),
        .i_fill_green  (r_fill_green),
        .i_fill_blue   (r_fill_blue),
        .i_fade        (fade),
        .o_valid       (o_valid),
        .o_shade_red   (o_shade_red),
        .o_shade_green (o_shade_green),
        .o_shade_blue  (o_shade_blue),
        .o_inside_disc (o_inside_disc)
    );

endmodule

// File: hdl/sedsh_chk.sv
// sedsh_chk: port-level checks of the soft edge disc shader, bound to the top level
// depends on sedsh_pkg (LATENCY, widths)

module sedsh_chk (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     start,
    input logic                                     busy,
    input logic signed [sedsh_pkg::OFFSET_BITS-1:0] i_offset_x,
    input logic                                     o_valid,
    input logic                                     o_inside_disc
);
    import sedsh_pkg::*;

    localparam logic [OFFSET_BITS-1:0] MOST_NEG = {1'b1, {(OFFSET_BITS-1){1'b0}}};

    logic accept;
    assign accept = start && !busy;

    // every transaction comes out exactly once
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted transaction produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result without an accepted transaction");

    // the most negative column offset is farther than any radius can reach
    a_far_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_offset_x == MOST_NEG)) |-> ##LATENCY !o_inside_disc)
        else $error("far pixel reported inside the disc");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind soft_edge_disc_shader sedsh_chk u_sedsh_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_offset_x    (i_offset_x),
    .o_valid       (o_valid),
    .o_inside_disc (o_inside_disc)
);
